// File: rtl/core/sfp_pkg.sv
// ----------------------------------------------------------------------------
// sfp_pkg
// Types, constants and the control store for the stereo frame-id pairing unit.
// ----------------------------------------------------------------------------
package sfp_pkg;

    localparam int ID_W        = 32;
    localparam int MAX_RESULTS = 16;
    localparam int RES_CW      = 5;

    localparam logic signed [ID_W-1:0] END_MARK    = -32'sd1;
    localparam logic [RES_CW-1:0]      RES_CAP     = 5'd16;

    typedef struct packed {
        logic                   cmd;
        logic signed [ID_W-1:0] line_id;
    } item_t;

    typedef struct packed {
        logic signed [ID_W-1:0] left_id;
        logic signed [ID_W-1:0] right_id;
        logic                   is_marker;
        logic                   overflow;
        logic                   last;
    } result_t;

    // sequencer steps
    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH,
        S_OVF,
        S_RDF,
        S_DEC_EQ,
        S_DEC_SCAN,
        S_DEC_MARK,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SCAN_EM,
        S_EMIT,
        S_FIN
    } step_t;

    typedef enum logic [3:0] {
        C_ALWAYS,
        C_IN_VALID,
        C_ROOM,
        C_NOPAIR,
        C_EQ,
        C_SCAN,
        C_MARK,
        C_SCAN_END,
        C_HIT,
        C_STOP
    } cond_t;

    typedef enum logic [3:0] {
        A_NONE,
        A_ACCEPT,
        A_WRITE,
        A_OVF,
        A_POP_EQ,
        A_SCAN_INIT,
        A_CLEAR,
        A_SCAN_POP,
        A_SCAN_DROP,
        A_SCAN_INC,
        A_SHIFT,
        A_FLUSH
    } act_t;

    typedef enum logic [1:0] {
        R_NONE,
        R_FRONT,
        R_SCAN
    } rd_t;

    // act fires when cond holds, fact otherwise; hold stalls on a busy output while a result is pending
    typedef struct packed {
        cond_t cond;
        act_t  act;
        act_t  fact;
        rd_t   rd;
        logic  hold;
        step_t jump;
        step_t next;
    } ucw_t;

    function automatic ucw_t ucode(input step_t s);
        ucw_t w;
        w = '{C_ALWAYS, A_NONE, A_NONE, R_NONE, 1'b0, S_IDLE, S_IDLE};
        case (s)
            S_IDLE:     w = '{C_IN_VALID, A_ACCEPT,    A_NONE,     R_NONE,  1'b0,
                              S_PUSH,     S_IDLE};
            S_PUSH:     w = '{C_ROOM,     A_WRITE,     A_NONE,     R_NONE,  1'b0,
                              S_RDF,      S_OVF};
            S_OVF:      w = '{C_ALWAYS,   A_OVF,       A_NONE,     R_NONE,  1'b0,
                              S_FIN,      S_FIN};
            S_RDF:      w = '{C_NOPAIR,   A_NONE,      A_NONE,     R_FRONT, 1'b0,
                              S_FIN,      S_DEC_EQ};
            S_DEC_EQ:   w = '{C_EQ,       A_POP_EQ,    A_NONE,     R_NONE,  1'b0,
                              S_EMIT,     S_DEC_SCAN};
            S_DEC_SCAN: w = '{C_SCAN,     A_SCAN_INIT, A_NONE,     R_NONE,  1'b0,
                              S_SCAN_RD,  S_DEC_MARK};
            S_DEC_MARK: w = '{C_MARK,     A_CLEAR,     A_NONE,     R_NONE,  1'b0,
                              S_EMIT,     S_FIN};
            S_SCAN_RD:  w = '{C_SCAN_END, A_NONE,      A_NONE,     R_SCAN,  1'b0,
                              S_FIN,      S_SCAN_CHK};
            S_SCAN_CHK: w = '{C_HIT,      A_SCAN_POP,  A_NONE,     R_NONE,  1'b0,
                              S_EMIT,     S_SCAN_EM};
            S_SCAN_EM:  w = '{C_STOP,     A_SCAN_DROP, A_SCAN_INC, R_NONE,  1'b0,
                              S_FIN,      S_SCAN_RD};
            S_EMIT:     w = '{C_ALWAYS,   A_SHIFT,     A_NONE,     R_NONE,  1'b1,
                              S_RDF,      S_RDF};
            S_FIN:      w = '{C_ALWAYS,   A_FLUSH,     A_NONE,     R_NONE,  1'b1,
                              S_IDLE,     S_IDLE};
            default:    w = '{C_ALWAYS,   A_NONE,      A_NONE,     R_NONE,  1'b0,
                              S_IDLE,     S_IDLE};
        endcase
        return w;
    endfunction

endpackage

// File: rtl/core/sfp_ram.sv
// ----------------------------------------------------------------------------
// sfp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sfp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/stereo_frame_id_pairing.sv
// ----------------------------------------------------------------------------
// stereo_frame_id_pairing
// Pushes frame ids onto left/right queues and pairs the queue fronts,
// driven by a microcoded sequencer over a small queue datapath.
// ----------------------------------------------------------------------------
//  channel | ports                     | payload
//  --------+---------------------------+------------------------
//  input   | s_valid, s_ready, s_item  | sfp_pkg::item_t
//  result  | m_valid, m_ready, m_item  | sfp_pkg::result_t
//
//  One item at a time. A push, each equal pair, a marker pair, a scan over
//  the queue entries it visits and an overflowed push all run through one
//  step of the control store per cycle, while no step stalls.
//  aresetn (synchronous) empties both queues; queue contents need no clearing.
//  A result waits in the output register; steps that hand one over stall
//  while it is not taken.
// ----------------------------------------------------------------------------
module stereo_frame_id_pairing #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  sfp_pkg::item_t    s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output sfp_pkg::result_t  m_item
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = CW + 1;

    sfp_pkg::step_t   upc_reg, upc_next;
    sfp_pkg::ucw_t    w;
    sfp_pkg::act_t    act_sel;

    logic [AW-1:0]    l_head_reg, l_head_next, r_head_reg, r_head_next;
    logic [CW-1:0]    l_cnt_reg, l_cnt_next, r_cnt_reg, r_cnt_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic             side_reg, side_next;
    logic [sfp_pkg::RES_CW-1:0] n_reg, n_next;
    logic             cmd_reg, cmd_next;
    logic signed [sfp_pkg::ID_W-1:0] id_reg, id_next;
    sfp_pkg::result_t res_reg, res_next;
    sfp_pkg::result_t pend_reg, pend_next;
    logic             pend_valid_reg, pend_valid_next;
    logic             m_valid_reg, m_valid_next;
    sfp_pkg::result_t m_item_reg, m_item_next;

    logic             stall, cond_ok, out_busy;
    logic signed [sfp_pkg::ID_W-1:0] l_dout, r_dout, s_dout, tgt;
    logic [sfp_pkg::ID_W-1:0] l_rdata, r_rdata;
    logic [CW-1:0]    s_cnt, c_cnt, idx_inc;
    logic [AW-1:0]    s_head, scan_addr, wr_addr;
    logic             l_we, r_we, l_re, r_re;
    logic [AW-1:0]    l_raddr, r_raddr;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                               input logic [CW-1:0] b);
        logic [SW-1:0] sum;
        sum = {{(SW-AW){1'b0}}, a} + {1'b0, b};
        if (sum >= SW'(QUEUE_DEPTH)) begin
            sum = sum - SW'(QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign w        = sfp_pkg::ucode(upc_reg);
    assign out_busy = m_valid_reg && !m_ready;
    assign stall    = w.hold && out_busy && pend_valid_reg;

    assign l_dout  = l_rdata;
    assign r_dout  = r_rdata;
    assign s_dout  = side_reg ? r_dout : l_dout;
    assign tgt     = side_reg ? l_dout : r_dout;
    assign s_cnt   = side_reg ? r_cnt_reg : l_cnt_reg;
    assign s_head  = side_reg ? r_head_reg : l_head_reg;
    assign c_cnt   = cmd_reg ? r_cnt_reg : l_cnt_reg;
    assign idx_inc = idx_reg + 1'b1;
    assign scan_addr = wrap_add(s_head, idx_reg);
    assign wr_addr   = wrap_add(cmd_reg ? r_head_reg : l_head_reg, c_cnt);

    always_comb begin
        case (w.cond)
            sfp_pkg::C_ALWAYS:   cond_ok = 1'b1;
            sfp_pkg::C_IN_VALID: cond_ok = s_valid;
            sfp_pkg::C_ROOM:     cond_ok = c_cnt < CW'(QUEUE_DEPTH);
            sfp_pkg::C_NOPAIR:   cond_ok = (l_cnt_reg == '0) || (r_cnt_reg == '0)
                                           || (n_reg == sfp_pkg::RES_CAP);
            sfp_pkg::C_EQ:       cond_ok = l_dout == r_dout;
            sfp_pkg::C_SCAN:     cond_ok = ((l_dout > r_dout) && (r_dout > 0))
                                           || ((r_dout > l_dout) && (l_dout > 0));
            sfp_pkg::C_MARK:     cond_ok = (l_dout == sfp_pkg::END_MARK)
                                           || (r_dout == sfp_pkg::END_MARK);
            sfp_pkg::C_SCAN_END: cond_ok = idx_reg >= s_cnt;
            sfp_pkg::C_HIT:      cond_ok = s_dout == tgt;
            sfp_pkg::C_STOP:     cond_ok = s_dout == sfp_pkg::END_MARK;
            default:             cond_ok = 1'b0;
        endcase
    end

    always_comb begin
        if (stall) begin
            act_sel  = sfp_pkg::A_NONE;
            upc_next = upc_reg;
        end else if (cond_ok) begin
            act_sel  = w.act;
            upc_next = w.jump;
        end else begin
            act_sel  = w.fact;
            upc_next = w.next;
        end
    end

    assign s_ready = (w.act == sfp_pkg::A_ACCEPT);

    // read port control
    always_comb begin
        l_re    = 1'b0;
        r_re    = 1'b0;
        l_raddr = l_head_reg;
        r_raddr = r_head_reg;
        case (w.rd)
            sfp_pkg::R_FRONT: begin
                l_re = 1'b1;
                r_re = 1'b1;
            end
            sfp_pkg::R_SCAN: begin
                l_re = !side_reg;
                r_re = side_reg;
                l_raddr = scan_addr;
                r_raddr = scan_addr;
            end
            default: begin
                l_re = 1'b0;
                r_re = 1'b0;
            end
        endcase
    end

    always_comb begin
        l_head_next     = l_head_reg;
        r_head_next     = r_head_reg;
        l_cnt_next      = l_cnt_reg;
        r_cnt_next      = r_cnt_reg;
        idx_next        = idx_reg;
        side_next       = side_reg;
        n_next          = n_reg;
        cmd_next        = cmd_reg;
        id_next         = id_reg;
        res_next        = res_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_item_next     = m_item_reg;
        l_we            = 1'b0;
        r_we            = 1'b0;

        case (act_sel)
            sfp_pkg::A_ACCEPT: begin
                cmd_next = s_item.cmd;
                id_next  = s_item.line_id;
                n_next   = '0;
            end
            sfp_pkg::A_WRITE: begin
                if (cmd_reg) begin
                    r_we       = 1'b1;
                    r_cnt_next = r_cnt_reg + 1'b1;
                end else begin
                    l_we       = 1'b1;
                    l_cnt_next = l_cnt_reg + 1'b1;
                end
            end
            sfp_pkg::A_OVF: begin
                pend_next       = '{'0, '0, 1'b0, 1'b1, 1'b0};
                pend_valid_next = 1'b1;
            end
            sfp_pkg::A_POP_EQ: begin
                res_next    = '{l_dout, r_dout, l_dout == sfp_pkg::END_MARK, 1'b0, 1'b0};
                l_head_next = wrap_add(l_head_reg, CW'(1));
                r_head_next = wrap_add(r_head_reg, CW'(1));
                l_cnt_next  = l_cnt_reg - 1'b1;
                r_cnt_next  = r_cnt_reg - 1'b1;
            end
            sfp_pkg::A_SCAN_INIT: begin
                side_next = l_dout > r_dout;
                idx_next  = '0;
            end
            sfp_pkg::A_CLEAR: begin
                res_next   = '{l_dout, r_dout, 1'b1, 1'b0, 1'b0};
                l_cnt_next = '0;
                r_cnt_next = '0;
            end
            sfp_pkg::A_SCAN_POP: begin
                res_next = '{tgt, tgt, 1'b0, 1'b0, 1'b0};
                if (side_reg) begin
                    r_head_next = wrap_add(r_head_reg, idx_inc);
                    r_cnt_next  = r_cnt_reg - idx_inc;
                    l_head_next = wrap_add(l_head_reg, CW'(1));
                    l_cnt_next  = l_cnt_reg - 1'b1;
                end else begin
                    l_head_next = wrap_add(l_head_reg, idx_inc);
                    l_cnt_next  = l_cnt_reg - idx_inc;
                    r_head_next = wrap_add(r_head_reg, CW'(1));
                    r_cnt_next  = r_cnt_reg - 1'b1;
                end
            end
            sfp_pkg::A_SCAN_DROP: begin
                if (side_reg) begin
                    r_head_next = scan_addr;
                    r_cnt_next  = r_cnt_reg - idx_reg;
                end else begin
                    l_head_next = scan_addr;
                    l_cnt_next  = l_cnt_reg - idx_reg;
                end
            end
            sfp_pkg::A_SCAN_INC: begin
                idx_next = idx_inc;
            end
            sfp_pkg::A_SHIFT: begin
                if (pend_valid_reg) begin
                    m_valid_next     = 1'b1;
                    m_item_next      = pend_reg;
                    m_item_next.last = 1'b0;
                end
                pend_next       = res_reg;
                pend_valid_next = 1'b1;
                n_next          = n_reg + 1'b1;
            end
            sfp_pkg::A_FLUSH: begin
                if (pend_valid_reg) begin
                    m_valid_next     = 1'b1;
                    m_item_next      = pend_reg;
                    m_item_next.last = 1'b1;
                end
                pend_valid_next = 1'b0;
            end
            default: begin
                l_we = 1'b0;
                r_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg        <= sfp_pkg::S_IDLE;
            l_head_reg     <= '0;
            r_head_reg     <= '0;
            l_cnt_reg      <= '0;
            r_cnt_reg      <= '0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            upc_reg        <= upc_next;
            l_head_reg     <= l_head_next;
            r_head_reg     <= r_head_next;
            l_cnt_reg      <= l_cnt_next;
            r_cnt_reg      <= r_cnt_next;
            n_reg          <= n_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        side_reg   <= side_next;
        cmd_reg    <= cmd_next;
        id_reg     <= id_next;
        res_reg    <= res_next;
        pend_reg   <= pend_next;
        m_item_reg <= m_item_next;
    end

    sfp_ram #(
        .WIDTH (sfp_pkg::ID_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_left_q (
        .aclk  (aclk),
        .we    (l_we),
        .waddr (wr_addr),
        .wdata (id_reg),
        .re    (l_re),
        .raddr (l_raddr),
        .rdata (l_rdata)
    );

    sfp_ram #(
        .WIDTH (sfp_pkg::ID_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_right_q (
        .aclk  (aclk),
        .we    (r_we),
        .waddr (wr_addr),
        .wdata (id_reg),
        .re    (r_re),
        .raddr (r_raddr),
        .rdata (r_rdata)
    );

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

// File: rtl/core/sfp_port_checker.sv
// ----------------------------------------------------------------------------
// sfp_port_checker
// Port-level checks on the pairing unit's channels, bound to the top.
// ----------------------------------------------------------------------------
module sfp_port_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input sfp_pkg::item_t    s_item,
    input logic              m_valid,
    input logic              m_ready,
    input sfp_pkg::result_t  m_item
);

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_item))
        else $error("input item changed while waiting");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result item changed while stalled");

    a_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.overflow |-> m_item.last && !m_item.is_marker
            && (m_item.left_id == 0) && (m_item.right_id == 0))
        else $error("overflow item malformed");

    a_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.overflow |-> m_item.is_marker ==
            ((m_item.left_id == sfp_pkg::END_MARK)
             || (m_item.right_id == sfp_pkg::END_MARK)))
        else $error("marker flag disagrees with ids");

    a_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.overflow && !m_item.is_marker
            |-> m_item.left_id == m_item.right_id)
        else $error("data pair with unequal ids");

endmodule

bind stereo_frame_id_pairing sfp_port_checker u_sfp_port_checker (.*);

// File: test/stereo_frame_id_pairing_tb.sv
// ----------------------------------------------------------------------------
// stereo_frame_id_pairing_tb
// Drives frame-id pushes into the pairing unit under random handshake gaps and
// stalls. A small scoreboard keeps its own left/right id queues, works out
// the pairs, marker pairs and dropped pushes that each push produces, and
// checks every result item field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module stereo_frame_id_pairing_tb;

    localparam int          QDEPTH     = 16;
    localparam int          N_ITEMS    = 230;
    localparam int          CALM_AFTER = 190;
    localparam int          TAIL       = 120;
    localparam int unsigned LIMIT      = 2000000;
    localparam bit          LEFT       = 1'b0;
    localparam bit          RIGHT      = 1'b1;

    class pair_board;
        int               lq[$];
        int               rq[$];
        sfp_pkg::result_t want_q[$];
        int               errors;
        int               n_push;
        int               n_pairs;
        int               n_markers;
        int               n_ovf;
        int               n_checked;

        function void take_fronts(output int lid, output int rid);
            lid = lq[0];
            rid = rq[0];
            lq.delete(0);
            rq.delete(0);
        endfunction

        // look for target in one queue; stale ids ahead of a hit or a marker go
        function bit scan_for(input bit on_right, input int target,
                              output int lid, output int rid);
            int cnt;
            int v;
            cnt = on_right ? rq.size() : lq.size();
            for (int k = 0; k < cnt; k++) begin
                v = on_right ? rq[k] : lq[k];
                if (v == sfp_pkg::END_MARK || v == target) begin
                    repeat (k) begin
                        if (on_right) rq.delete(0);
                        else lq.delete(0);
                    end
                    if (v == sfp_pkg::END_MARK) return 1'b0;
                    take_fronts(lid, rid);
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function bit match_fronts(output int lid, output int rid);
            int a;
            int b;
            if (lq.size() == 0 || rq.size() == 0) return 1'b0;
            a = lq[0];
            b = rq[0];
            if (a == b) begin
                take_fronts(lid, rid);
                return 1'b1;
            end
            if (a > b && b > 0) return scan_for(RIGHT, a, lid, rid);
            if (b > a && a > 0) return scan_for(LEFT, b, lid, rid);
            if (a == sfp_pkg::END_MARK || b == sfp_pkg::END_MARK) begin
                lid = a;
                rid = b;
                lq.delete();
                rq.delete();
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_push(sfp_pkg::item_t it);
            sfp_pkg::result_t r;
            int               lid;
            int               rid;
            int               n;
            n_push++;
            if ((it.cmd ? rq.size() : lq.size()) >= QDEPTH) begin
                r = '0;
                r.overflow = 1'b1;
                r.last = 1'b1;
                want_q.insert(want_q.size(), r);
                n_ovf++;
                return;
            end
            if (it.cmd) rq.insert(rq.size(), it.line_id);
            else lq.insert(lq.size(), it.line_id);
            n = 0;
            while (n < sfp_pkg::MAX_RESULTS && match_fronts(lid, rid)) begin
                r = '0;
                r.left_id = lid;
                r.right_id = rid;
                r.is_marker = (lid == sfp_pkg::END_MARK || rid == sfp_pkg::END_MARK);
                if (r.is_marker) n_markers++;
                want_q.insert(want_q.size(), r);
                n++;
            end
            n_pairs += n;
            if (n > 0) begin
                r = want_q[want_q.size() - 1];
                r.last = 1'b1;
                want_q[want_q.size() - 1] = r;
            end
        endfunction

        function void check_result(sfp_pkg::result_t got);
            sfp_pkg::result_t want;
            n_checked++;
            if (want_q.size() == 0) begin
                $display("%0t: result with nothing expected: %p", $time, got);
                errors++;
                return;
            end
            want = want_q[0];
            want_q.delete(0);
            if (got.left_id !== want.left_id) begin
                $display("%0t: left_id expected %0d, got %0d", $time, want.left_id,
                         got.left_id);
                errors++;
            end
            if (got.right_id !== want.right_id) begin
                $display("%0t: right_id expected %0d, got %0d", $time, want.right_id,
                         got.right_id);
                errors++;
            end
            if (got.is_marker !== want.is_marker) begin
                $display("%0t: is_marker expected %b, got %b", $time, want.is_marker,
                         got.is_marker);
                errors++;
            end
            if (got.overflow !== want.overflow) begin
                $display("%0t: overflow expected %b, got %b", $time, want.overflow,
                         got.overflow);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last expected %b, got %b", $time, want.last, got.last);
                errors++;
            end
        endfunction

        function int pending();
            return want_q.size();
        endfunction
    endclass

    logic             aclk    = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    sfp_pkg::item_t   s_item  = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    sfp_pkg::result_t m_item;

    pair_board   board = new();
    bit          calm;
    int          sent;
    int unsigned cycles;

    stereo_frame_id_pairing #(
        .QUEUE_DEPTH (QDEPTH)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) board.note_push(s_item);
            if (m_valid && m_ready) board.check_result(m_item);
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     board.pending());
            $display("status: fail");
            $finish;
        end
    end

    // result side: random stall bursts, none once the run turns calm
    initial begin
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
        end
    end

    task automatic push_id(input bit side, input int id);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_item.cmd     <= side;
        s_item.line_id <= id;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
    endtask

    task automatic end_scan();
        bit first;
        first = $urandom_range(0, 1);
        push_id(first, sfp_pkg::END_MARK);
        push_id(!first, sfp_pkg::END_MARK);
    endtask

    initial begin
        int  base;
        int  lines;
        bit  first;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // fill left while right is empty, overflow it, then clear with a marker
        for (int k = 0; k < QDEPTH; k++)
            push_id(LEFT, (k == 0) ? 0 : (k == 1) ? 32'h7FFF_FFFF : k);
        push_id(LEFT, 99);
        push_id(RIGHT, sfp_pkg::END_MARK);
        // both fronts end-of-scan: equal rule, no clear
        push_id(LEFT, sfp_pkg::END_MARK);
        push_id(RIGHT, sfp_pkg::END_MARK);
        // right scanned for the larger left id, stale entry dropped
        push_id(LEFT, 32'h7FFF_FFFF);
        push_id(RIGHT, 3);
        push_id(RIGHT, 32'h7FFF_FFFF);
        // left scan runs into a marker, then the marker front clears both
        push_id(LEFT, 20);
        push_id(RIGHT, 25);
        push_id(LEFT, sfp_pkg::END_MARK);
        push_id(LEFT, 40);

        while (sent < N_ITEMS) begin
            if (sent >= CALM_AFTER) calm = 1'b1;
            if (board.lq.size() + board.rq.size() > 12) end_scan();
            if ($urandom_range(0, 4) != 0) begin
                // one scan: rising ids on both sides, some lines missing on one
                base  = $urandom_range(1, 32'h7FFF_FF00);
                lines = $urandom_range(1, 10);
                for (int k = 0; k < lines; k++) begin
                    first = $urandom_range(0, 1);
                    if ($urandom_range(0, 9) != 0) push_id(first, base + k);
                    if ($urandom_range(0, 9) != 0) push_id(!first, base + k);
                end
                end_scan();
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    case ($urandom_range(0, 3))
                        0:       push_id($urandom_range(0, 1), sfp_pkg::END_MARK);
                        1:       push_id($urandom_range(0, 1), $urandom() >> 1);
                        default: push_id($urandom_range(0, 1), $urandom_range(1, 20));
                    endcase
                end
            end
        end
        s_valid <= 1'b0;
        @(posedge aclk);

        while (board.pending() != 0) @(posedge aclk);
        repeat (TAIL) @(posedge aclk);

        if (board.pending() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, board.pending());
            board.errors++;
        end

        $display("pushed %0d ids: %0d pairs out, %0d of them end-of-scan markers",
                 board.n_push, board.n_pairs, board.n_markers);
        $display("%0d pushes dropped on a full queue, %0d result items checked, %0d errors",
                 board.n_ovf, board.n_checked, board.errors);
        if (board.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
